// ===== src/code_point_to_byte_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// code point encoder assertion macros
// clocked assertion helpers shared by the encoder modules
// ----------------------------------------------------------------------------
`ifndef CODE_POINT_TO_BYTE_ENCODER_ASSERT_SVH
`define CODE_POINT_TO_BYTE_ENCODER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CPBE_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CPBE_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== src/cpbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cpbe_pkg
// types and constants shared by the code point encoder modules
// ----------------------------------------------------------------------------
package cpbe_pkg;

    localparam int CP_W   = 22;
    localparam int BYTE_W = 8;
    localparam int MAX_BYTES = 4;
    localparam int IDX_W  = 2;

    typedef enum logic [1:0] {
        ENC_BYTE    = 2'd0,
        ENC_UTF8    = 2'd1,
        ENC_UTF16LE = 2'd2,
        ENC_UTF16BE = 2'd3
    } t_enc;

    // register addresses, index taken from paddr[2]
    localparam logic REG_OUTPUT_ENCODING = 1'b0;

    localparam logic [20:0] CP_LIMIT    = 21'h110000;
    localparam logic [20:0] CP_SUPP     = 21'h010000;
    localparam logic [20:0] CP_SUR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SUR_END  = 21'h00E000;
    localparam logic [20:0] CP_UTF8_1   = 21'h000080;
    localparam logic [20:0] CP_UTF8_2   = 21'h000800;
    localparam logic [20:0] CP_BYTE_MAX = 21'h0000FF;

    // encoded bytes in emission order plus index of the final byte
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]                 last_idx;
    } t_word;

    // queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/cpbe_front.sv =====
// ----------------------------------------------------------------------------
// cpbe_front
// accepts code points, drops invalid ones and encodes the rest into words
// ----------------------------------------------------------------------------
module cpbe_front (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [cpbe_pkg::CP_W-1:0] i_code_point,
    input  cpbe_pkg::t_enc               i_enc,
    input  cpbe_pkg::t_q_status          i_q_status,
    output logic                         o_push,
    output cpbe_pkg::t_word              o_word
);
    import cpbe_pkg::*;

    logic [20:0] cp;
    logic        neg;
    logic        emit;
    logic [19:0] v;
    logic [15:0] w_hi;
    logic [15:0] w_lo;
    logic        big;
    t_word       word;

    assign cp  = i_code_point[20:0];
    assign neg = i_code_point[CP_W-1];
    assign v   = 20'(cp - CP_SUPP);
    assign big = (i_enc == ENC_UTF16BE);

    always_comb begin
        word = '0;
        emit = 1'b0;
        w_hi = 16'h0000;
        w_lo = 16'h0000;
        if (!neg && cp < CP_LIMIT) begin
            case (i_enc)
                ENC_UTF8: begin
                    emit = 1'b1;
                    if (cp < CP_UTF8_1) begin
                        word.bytes[0] = {1'b0, cp[6:0]};
                        word.last_idx = 2'd0;
                    end else if (cp < CP_UTF8_2) begin
                        word.bytes[0] = {3'b110, cp[10:6]};
                        word.bytes[1] = {2'b10, cp[5:0]};
                        word.last_idx = 2'd1;
                    end else if (cp < CP_SUPP) begin
                        word.bytes[0] = {4'b1110, cp[15:12]};
                        word.bytes[1] = {2'b10, cp[11:6]};
                        word.bytes[2] = {2'b10, cp[5:0]};
                        word.last_idx = 2'd2;
                    end else begin
                        word.bytes[0] = {5'b11110, cp[20:18]};
                        word.bytes[1] = {2'b10, cp[17:12]};
                        word.bytes[2] = {2'b10, cp[11:6]};
                        word.bytes[3] = {2'b10, cp[5:0]};
                        word.last_idx = 2'd3;
                    end
                end
                ENC_UTF16LE, ENC_UTF16BE: begin
                    if (cp < CP_SUR_LO || (cp >= CP_SUR_END && cp < CP_SUPP)) begin
                        emit = 1'b1;
                        w_hi = cp[15:0];
                        word.bytes[0] = big ? w_hi[15:8] : w_hi[7:0];
                        word.bytes[1] = big ? w_hi[7:0] : w_hi[15:8];
                        word.last_idx = 2'd1;
                    end else if (cp >= CP_SUPP) begin
                        // surrogate pair, high half first
                        emit = 1'b1;
                        w_hi = {6'b110110, v[19:10]};
                        w_lo = {6'b110111, v[9:0]};
                        word.bytes[0] = big ? w_hi[15:8] : w_hi[7:0];
                        word.bytes[1] = big ? w_hi[7:0] : w_hi[15:8];
                        word.bytes[2] = big ? w_lo[15:8] : w_lo[7:0];
                        word.bytes[3] = big ? w_lo[7:0] : w_lo[15:8];
                        word.last_idx = 2'd3;
                    end
                end
                default: begin
                    if (cp <= CP_BYTE_MAX) begin
                        emit = 1'b1;
                        word.bytes[0] = cp[7:0];
                        word.last_idx = 2'd0;
                    end
                end
            endcase
        end
    end

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready && emit;
    assign o_word  = word;

endmodule

// ===== src/cpbe_fifo.sv =====
// ----------------------------------------------------------------------------
// cpbe_fifo
// short queue of encoded words between the front and back ends
// ----------------------------------------------------------------------------
`include "code_point_to_byte_encoder_assert.svh"

module cpbe_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cpbe_pkg::t_word     i_word,
    input  logic                i_pop,
    output cpbe_pkg::t_word     o_word,
    output cpbe_pkg::t_q_status o_status
);
    import cpbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_word              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_word       = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    `CPBE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, o_status.full, !i_push, "push into full queue")
    `CPBE_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, o_status.empty, !i_pop, "pop from empty queue")
    `CPBE_ASSERT_IMP(a_ptr_match, i_clk, i_rst_n, o_status.empty || o_status.full, r_wr_ptr == r_rd_ptr, "pointers disagree with count")

endmodule

// ===== src/cpbe_back.sv =====
// ----------------------------------------------------------------------------
// cpbe_back
// serializes queued words into single bytes behind an output register
// ----------------------------------------------------------------------------
`include "code_point_to_byte_encoder_assert.svh"

module cpbe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpbe_pkg::t_word     i_word,
    input  cpbe_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_last_byte
);
    import cpbe_pkg::*;

    t_word              r_word;
    logic               r_have, n_have;
    logic [IDX_W-1:0]   r_idx,  n_idx;
    logic               r_valid, n_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_last_byte;
    logic               load;
    logic               load_last;

    assign load      = r_have && (!r_valid || i_ready);
    assign load_last = load && (r_idx == r_word.last_idx);
    // fetch the next word when idle or when the current one finishes
    assign o_pop     = !i_q_status.empty && (!r_have || load_last);

    always_comb begin
        n_have  = r_have;
        n_idx   = r_idx;
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
            n_idx   = r_idx + 1'b1;
        end
        if (load_last) begin
            n_have = 1'b0;
        end
        if (o_pop) begin
            n_have = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_have  <= n_have;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_word;
        end
        if (load) begin
            r_out_byte  <= r_word.bytes[r_idx];
            r_last_byte <= (r_idx == r_word.last_idx);
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last_byte;

    `CPBE_ASSERT_IMP(a_idx_in_word, i_clk, i_rst_n, r_have, r_idx <= r_word.last_idx, "byte index past end of word")
    `CPBE_ASSERT_NXT(a_pop_restart, i_clk, i_rst_n, o_pop, r_have && r_idx == '0, "popped word not started at byte zero")
    `CPBE_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, load, o_valid, "loaded byte not presented")

endmodule

// ===== src/code_point_to_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// code_point_to_byte_encoder
// encodes code points into byte, utf-8 or utf-16 byte streams
// ----------------------------------------------------------------------------
// One code point enters per transaction and leaves as 0 to 4 output bytes,
// one byte per cycle while i_ready is high, with o_last_byte marking the
// final byte of each code point. The input side takes a new code point
// every cycle while the word queue (DEPTH entries) has room. An item gives
// 1 byte in byte mode, 1 to 4 bytes in utf-8 and 2 or 4 bytes in utf-16;
// dropped code points are taken on the input but give no bytes. The
// output encoding register at address 0 should be written only while no
// transaction is in flight.
module code_point_to_byte_encoder #(
    parameter int DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [cpbe_pkg::CP_W-1:0]  i_code_point,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [7:0]                        o_out_byte,
    output logic                              o_last_byte
);
    import cpbe_pkg::*;

    t_enc       r_enc;
    logic       push;
    logic       pop;
    t_word      front_word;
    t_word      q_word;
    t_q_status  q_status;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_OUTPUT_ENCODING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc <= ENC_BYTE;
        end else if (wr_en) begin
            r_enc <= t_enc'(pwdata[1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_OUTPUT_ENCODING) begin
            prdata = {30'd0, r_enc};
        end
    end

    cpbe_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_code_point (i_code_point),
        .i_enc        (r_enc),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_word       (front_word)
    );

    cpbe_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (front_word),
        .i_pop    (pop),
        .o_word   (q_word),
        .o_status (q_status)
    );

    cpbe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (q_word),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
